// File: rtl/first_fit_heap_allocator_macros.svh
// Assertion macros for the heap allocator.
// Included by modules that carry concurrent checks.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
// Implication check under synchronous reset.
`define FFHA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication check under synchronous reset.
`define FFHA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/ffha_pkg.sv
// Package for the first-fit heap allocator: sizes, beat structs, codes, states.
// No dependencies.
package ffha_pkg;
    localparam int ArenaBytes  = 8192;
    localparam int MaxBlocks   = 64;
    localparam int HeaderBytes = 17;
    localparam int MinCapacity = 24;
    localparam int SlotW = $clog2(MaxBlocks);
    localparam int OffW  = $clog2(ArenaBytes) + 1;
    localparam int AddrW = 13;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_OOM = 2'd1, ST_NULL = 2'd2, ST_UNKNOWN = 2'd3
    } t_status;

    typedef enum logic {OP_ALLOC = 1'b0, OP_FREE = 1'b1} t_op;

    typedef struct packed {
        logic        opcode;
        logic [15:0] request_size;
        logic [12:0] address;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [12:0] granted_address;
    } t_out_beat;

    typedef struct packed {
        logic [OffW-1:0]  hdr;
        logic [OffW-1:0]  cap;
        logic             is_free;
        logic             has_next;
        logic [SlotW-1:0] next;
    } t_blk;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_RDN, S_EVAL, S_MERGE, S_SPARE, S_SPLIT, S_DONE
    } t_state;
endpackage

// File: rtl/first_fit_heap_allocator.sv
// Heap allocator: one request at a time over a block table held in a memory with one write and one read port.
// Steps: a null free goes straight to the result; otherwise each visited block is
// read, free neighbours are merged, an alloc that leaves room scans for a spare slot
// and splits, and the block is written back once the output is free.
// A new request is taken only after the last one is done; a waiting result beat does not block input.
// Reset restores one free whole-arena block in slot zero (per-slot used/free bits).
`include "first_fit_heap_allocator_macros.svh"
module first_fit_heap_allocator
    import ffha_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_data
);
    // Block table memory and per-slot flags
    t_blk r_mem [MaxBlocks];
    logic [MaxBlocks-1:0] r_used, n_used;
    logic [MaxBlocks-1:0] r_free, n_free;

    t_state r_state, n_state;
    t_in_beat r_req, n_req;
    logic [16:0] r_q, n_q;
    logic [SlotW-1:0] r_s, n_s;
    logic [SlotW:0] r_steps, n_steps, r_guard, n_guard;
    t_blk r_cur, n_cur;
    logic [SlotW:0] r_scan, n_scan;
    logic r_ov, n_ov;
    t_out_beat r_out, n_out;
    t_out_beat r_res, n_res;

    // Memory port control
    logic we;
    logic [SlotW-1:0] waddr, raddr;
    t_blk wdata, r_rdata;

    // Slot zero has a reset value until its first write
    logic r_z_wr;

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rdata <= r_mem[raddr];
    end

    t_blk rd_blk;
    logic [SlotW-1:0] r_raddr;
    always_ff @(posedge i_clk) r_raddr <= raddr;
    always_comb begin
        rd_blk = r_rdata;
        if (r_raddr == '0 && !r_z_wr) begin
            rd_blk.hdr = '0;
            rd_blk.cap = OffW'(ArenaBytes - HeaderBytes);
            rd_blk.has_next = 1'b0;
            rd_blk.next = '0;
        end
        rd_blk.is_free = r_free[r_raddr];
    end

    logic [OffW:0] end_cur;
    logic [17:0] need_split;
    logic fits;
    always_comb begin
        end_cur = {1'b0, r_cur.hdr} + (OffW+1)'(HeaderBytes) + {1'b0, r_cur.cap};
        need_split = {1'b0, r_q} + 18'(HeaderBytes + MinCapacity);
        fits = r_free[r_s] && ({3'b0, r_cur.cap} >= r_q);
    end

    always_comb begin
        n_state = r_state; n_req = r_req; n_q = r_q; n_s = r_s;
        n_steps = r_steps; n_guard = r_guard; n_cur = r_cur; n_scan = r_scan;
        n_out = r_out; n_res = r_res; n_used = r_used; n_free = r_free;
        // Drop the output beat once it is taken
        n_ov = r_ov && i_stall;
        we = 1'b0; waddr = r_s; wdata = r_cur; raddr = r_s;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req = i_data;
                    n_q = (i_data.request_size < 16'(MinCapacity)) ?
                          17'(MinCapacity) : {1'b0, i_data.request_size};
                    n_s = '0; n_steps = '0; raddr = '0;
                    if (i_data.opcode == OP_FREE && i_data.address == '0) begin
                        n_res = '{status: ST_NULL, granted_address: '0};
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            // Read current block; start merge count
            S_RD: begin
                n_cur = rd_blk; n_guard = '0;
                if (r_req.opcode == OP_FREE) begin
                    n_state = S_EVAL;
                end else begin
                    raddr = rd_blk.next;
                    n_state = (rd_blk.has_next && rd_blk.is_free) ? S_MERGE : S_EVAL;
                end
            end
            // Absorb one free neighbor per pass
            S_MERGE: begin
                if (r_free[r_cur.next] && end_cur[OffW-1:0] == rd_blk.hdr &&
                    end_cur[OffW] == 1'b0 && r_guard < (SlotW+1)'(MaxBlocks)) begin
                    n_cur.cap = r_cur.cap + OffW'(HeaderBytes) + rd_blk.cap;
                    n_cur.has_next = rd_blk.has_next;
                    n_cur.next = rd_blk.next;
                    n_used[r_cur.next] = 1'b0;
                    n_free[r_cur.next] = 1'b0;
                    n_guard = r_guard + 1'b1;
                    we = 1'b1; wdata = n_cur;
                    raddr = rd_blk.next;
                    n_state = rd_blk.has_next ? S_RDN : S_EVAL;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_RDN: begin
                raddr = r_cur.next;
                n_state = S_MERGE;
            end
            S_EVAL: begin
                if (r_req.opcode == OP_FREE) begin
                    if (end_cur[OffW-1:0] - OffW'(r_cur.cap) == OffW'(r_req.address) &&
                        {1'b0, r_cur.hdr} + (OffW+1)'(HeaderBytes) ==
                        (OffW+1)'(r_req.address)) begin
                        n_free[r_s] = 1'b1;
                        n_req.opcode = OP_ALLOC;
                        n_q = '1;
                        raddr = r_cur.next;
                        n_res = '{status: ST_OK, granted_address: '0};
                        n_guard = '0;
                        n_state = r_cur.has_next ? S_RDN : S_DONE;
                    end else if (!r_cur.has_next || r_steps == (SlotW+1)'(MaxBlocks-1)) begin
                        n_res = '{status: ST_UNKNOWN, granted_address: '0};
                        n_state = S_DONE;
                    end else begin
                        n_s = r_cur.next; raddr = r_cur.next;
                        n_steps = r_steps + 1'b1; n_state = S_RD;
                    end
                end else if (r_q == '1) begin
                    n_state = S_DONE;
                end else if (fits) begin
                    n_res = '{status: ST_OK,
                              granted_address: AddrW'(r_cur.hdr + OffW'(HeaderBytes))};
                    n_scan = '0;
                    n_state = ({1'b0, r_cur.cap} >= need_split[OffW:0] &&
                               need_split[17:OffW+1] == '0) ? S_SPARE : S_DONE;
                    if (n_state == S_DONE) n_free[r_s] = 1'b0;
                end else if (!r_cur.has_next || r_steps == (SlotW+1)'(MaxBlocks-1)) begin
                    n_res = '{status: ST_OOM, granted_address: '0};
                    n_state = S_DONE;
                end else begin
                    n_s = r_cur.next; raddr = r_cur.next;
                    n_steps = r_steps + 1'b1; n_state = S_RD;
                end
            end
            // Scan used map for a spare slot, one per cycle
            S_SPARE: begin
                if (r_scan == (SlotW+1)'(MaxBlocks)) begin
                    n_free[r_s] = 1'b0; n_state = S_DONE;
                end else if (!r_used[r_scan[SlotW-1:0]]) begin
                    n_state = S_SPLIT;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            // Write the tail block, then the shrunk head
            S_SPLIT: begin
                we = 1'b1; waddr = r_scan[SlotW-1:0];
                wdata.hdr = r_cur.hdr + OffW'(HeaderBytes) + OffW'(r_q);
                wdata.cap = r_cur.cap - OffW'(r_q) - OffW'(HeaderBytes);
                wdata.is_free = 1'b1;
                wdata.has_next = r_cur.has_next;
                wdata.next = r_cur.next;
                n_used[r_scan[SlotW-1:0]] = 1'b1;
                n_free[r_scan[SlotW-1:0]] = 1'b1;
                n_free[r_s] = 1'b0;
                n_cur.cap = OffW'(r_q);
                n_cur.has_next = 1'b1;
                n_cur.next = r_scan[SlotW-1:0];
                n_state = S_DONE;
            end
            // Write back the block (not for a null free) and hand the result over once the output is free
            S_DONE: begin
                if (!r_ov || !i_stall) begin
                    we = !(r_req.opcode == OP_FREE && r_req.address == '0);
                    n_out = r_res; n_ov = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov <= 1'b0;
            r_used <= MaxBlocks'(1);
            r_free <= MaxBlocks'(1);
            r_z_wr <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov <= n_ov;
            r_used <= n_used;
            r_free <= n_free;
            if (we && waddr == '0) r_z_wr <= 1'b1;
        end
        r_req <= n_req; r_q <= n_q; r_s <= n_s; r_steps <= n_steps;
        r_guard <= n_guard; r_cur <= n_cur; r_scan <= n_scan; r_out <= n_out;
        r_res <= n_res;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ov;
    assign o_data  = r_out;

    `FFHA_ASSERT_IMP(a_slot0_used, i_clk, i_rst_n, 1'b1, r_used[0])
    `FFHA_ASSERT_IMP(a_free_used, i_clk, i_rst_n, 1'b1, (r_free & ~r_used) == '0)
    `FFHA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, r_ov && i_stall, r_ov && $stable(r_out))
    `FFHA_ASSERT_NXT(a_done_out, i_clk, i_rst_n, r_state == S_DONE, r_ov)
endmodule

// File: dv/testbench.sv
// Self-checking testbench for first_fit_heap_allocator: alloc/free beats with a
// built-in first-fit heap predictor. Depends on ffha_pkg and the allocator RTL.
`timescale 1ns / 100ps
module testbench;
    import ffha_pkg::*;

    localparam int CycleLimit = 2000000;

    typedef struct {
        int unsigned hdr;
        int unsigned cap;
        bit          is_free;
        bit          has_next;
        int unsigned nxt;
    } heap_blk_t;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_beat  i_data = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_beat o_data;

    heap_blk_t heap[MaxBlocks];
    bit        slot_busy[MaxBlocks];

    t_in_beat  req_q[$];
    t_out_beat grant_q[$];
    int unsigned live_q[$];

    int  n_err = 0;
    int  n_sent = 0;
    int  n_done = 0;
    int  n_oom = 0;
    int  n_unknown = 0;
    int  cycles = 0;
    int  gap_left = 0;
    int  hold_left = 0;
    bit  calm = 1'b0;
    bit  long_hold = 1'b0;
    bit  drain_done = 1'b0;

    first_fit_heap_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    always #6 i_clk = ~i_clk;

    // Merge a free block with the free blocks that follow it.
    function automatic void coalesce(int unsigned s);
        int unsigned guard;
        int unsigned n;
        guard = 0;
        while (guard < MaxBlocks && heap[s].has_next) begin
            n = heap[s].nxt;
            if (n >= MaxBlocks || !heap[s].is_free || !heap[n].is_free) return;
            if (heap[s].hdr + HeaderBytes + heap[s].cap != heap[n].hdr) return;
            heap[s].cap += HeaderBytes + heap[n].cap;
            heap[s].has_next = heap[n].has_next;
            heap[s].nxt = heap[n].nxt;
            slot_busy[n] = 1'b0;
            guard++;
        end
    endfunction

    function automatic void heap_reset();
        foreach (heap[i]) begin
            heap[i] = '{0, 0, 1'b0, 1'b0, 0};
            slot_busy[i] = 1'b0;
        end
        heap[0].cap = ArenaBytes - HeaderBytes;
        heap[0].is_free = 1'b1;
        slot_busy[0] = 1'b1;
    endfunction

    // Apply one request to the heap and return the expected response beat.
    function automatic t_out_beat heap_apply(t_in_beat b);
        t_out_beat r;
        int unsigned s;
        int unsigned steps;
        int unsigned q;
        int ns;
        r = '0;
        s = 0;
        steps = 0;
        if (b.opcode == OP_ALLOC) begin
            q = (b.request_size < MinCapacity) ? MinCapacity : b.request_size;
            while (steps < MaxBlocks) begin
                coalesce(s);
                if (heap[s].is_free && heap[s].cap >= q) begin
                    if (q + HeaderBytes + MinCapacity <= heap[s].cap) begin
                        ns = -1;
                        for (int i = 0; i < MaxBlocks; i++)
                            if (ns < 0 && !slot_busy[i]) ns = i;
                        if (ns >= 0) begin
                            heap[ns].hdr = heap[s].hdr + HeaderBytes + q;
                            heap[ns].cap = heap[s].cap - q - HeaderBytes;
                            heap[ns].is_free = 1'b1;
                            heap[ns].has_next = heap[s].has_next;
                            heap[ns].nxt = heap[s].nxt;
                            slot_busy[ns] = 1'b1;
                            heap[s].cap = q;
                            heap[s].has_next = 1'b1;
                            heap[s].nxt = ns;
                        end
                    end
                    heap[s].is_free = 1'b0;
                    r.granted_address = 13'((heap[s].hdr + HeaderBytes) & 32'h1FFF);
                    return r;
                end
                if (!heap[s].has_next || heap[s].nxt >= MaxBlocks) break;
                s = heap[s].nxt;
                steps++;
            end
            r.status = ST_OOM;
            return r;
        end
        if (b.address == 0) begin
            r.status = ST_NULL;
            return r;
        end
        while (steps < MaxBlocks) begin
            if (heap[s].hdr + HeaderBytes == b.address) begin
                heap[s].is_free = 1'b1;
                coalesce(s);
                return r;
            end
            if (!heap[s].has_next || heap[s].nxt >= MaxBlocks) break;
            s = heap[s].nxt;
            steps++;
        end
        r.status = ST_UNKNOWN;
        return r;
    endfunction

    function automatic t_in_beat mk_req(t_op op, int unsigned sz, int unsigned adr);
        t_in_beat b;
        b.opcode = op;
        b.request_size = 16'(sz);
        b.address = 13'(adr);
        return b;
    endfunction

    // Build a random request biased toward freeing live grants.
    function automatic t_in_beat rand_req();
        int unsigned pick;
        int unsigned k;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            k = $urandom_range(0, 9);
            if (k < 6) return mk_req(OP_ALLOC, $urandom_range(0, 200), $urandom);
            if (k < 9) return mk_req(OP_ALLOC, $urandom_range(0, 1500), $urandom);
            return mk_req(OP_ALLOC, $urandom_range(0, 65535), $urandom);
        end
        if (pick < 88 && live_q.size() > 0) begin
            k = $urandom_range(0, live_q.size() - 1);
            return mk_req(OP_FREE, $urandom, live_q[k]);
        end
        if (pick < 94) return mk_req(OP_FREE, $urandom, $urandom_range(1, 8191));
        if (pick < 97) return mk_req(OP_FREE, $urandom, 0);
        return mk_req(OP_FREE, $urandom, HeaderBytes);
    endfunction

    // Fill the request queue: directed corners first, then random traffic.
    initial begin
        req_q.push_back(mk_req(OP_FREE, 16'hFFFF, 0));
        req_q.push_back(mk_req(OP_FREE, 0, 13'h1FFF));
        req_q.push_back(mk_req(OP_ALLOC, 0, 0));
        req_q.push_back(mk_req(OP_ALLOC, 1, 13'h1FFF));
        req_q.push_back(mk_req(OP_ALLOC, 24, 0));
        req_q.push_back(mk_req(OP_ALLOC, 65535, 0));
        req_q.push_back(mk_req(OP_FREE, 0, HeaderBytes));
        req_q.push_back(mk_req(OP_FREE, 0, HeaderBytes));
        req_q.push_back(mk_req(OP_FREE, 0, HeaderBytes + 41));
        req_q.push_back(mk_req(OP_FREE, 0, 5));
        req_q.push_back(mk_req(OP_ALLOC, ArenaBytes - HeaderBytes, 0));
        req_q.push_back(mk_req(OP_ALLOC, 1, 0));
        req_q.push_back(mk_req(OP_FREE, 0, HeaderBytes));
        req_q.push_back(mk_req(OP_ALLOC, ArenaBytes - 2 * HeaderBytes - 30, 0));
        // Exhaust the slot table so a split finds no spare slot.
        for (int i = 0; i < 70; i++) req_q.push_back(mk_req(OP_ALLOC, 24, 0));
        req_q.push_back(mk_req(OP_ALLOC, 40, 0));
        for (int i = 0; i < 1200; i++) req_q.push_back(rand_req());
    end

    // Drive request beats; the live list tracks what the model granted.
    always @(posedge i_clk) begin
        t_in_beat nb;
        t_out_beat ex;
        int idx;
        cycles <= cycles + 1;
        if (i_rst_n && i_valid && !o_stall) begin
            ex = heap_apply(i_data);
            grant_q.push_back(ex);
            if (i_data.opcode == OP_ALLOC && ex.status == ST_OK)
                live_q.push_back(ex.granted_address);
            if (i_data.opcode == OP_FREE && ex.status == ST_OK) begin
                idx = -1;
                foreach (live_q[i]) if (live_q[i] == i_data.address) idx = i;
                if (idx >= 0) live_q.delete(idx);
            end
            n_sent <= n_sent + 1;
        end
        if (!i_rst_n || (i_valid && o_stall)) begin
            // hold the stalled beat
        end else if (n_sent >= 700 && !drain_done) begin
            // pause until every expected beat has come back
            i_valid <= 1'b0;
            if (grant_q.size() == 0) drain_done <= 1'b1;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            i_valid <= 1'b0;
        end else if (req_q.size() == 0) begin
            i_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            gap_left <= $urandom_range(0, 6);
            i_valid <= 1'b0;
        end else begin
            nb = req_q.pop_front();
            i_data <= nb;
            i_valid <= 1'b1;
        end
    end

    // Stall the response side in bursts, once for a long stretch.
    always @(posedge i_clk) begin
        if (!long_hold && n_sent == 300) begin
            long_hold <= 1'b1;
            hold_left <= 3000;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            hold_left <= $urandom_range(0, 6);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Compare each response beat with the oldest expected one.
    always @(posedge i_clk) begin
        t_out_beat ex;
        if (i_rst_n && o_valid && !i_stall) begin
            n_done <= n_done + 1;
            if (grant_q.size() == 0) begin
                $error("response beat with nothing expected");
                n_err <= n_err + 1;
            end else begin
                ex = grant_q.pop_front();
                if (o_data.status == ST_OOM) n_oom <= n_oom + 1;
                if (o_data.status == ST_UNKNOWN) n_unknown <= n_unknown + 1;
                if (o_data.status !== ex.status) begin
                    $error("status: expected %0d actual %0d", ex.status, o_data.status);
                    n_err <= n_err + 1;
                end
                if (o_data.granted_address !== ex.granted_address) begin
                    $error("granted_address: expected %0d actual %0d",
                           ex.granted_address, o_data.granted_address);
                    n_err <= n_err + 1;
                end
            end
        end
    end

    // Reset, then wait for the queue to drain and finish.
    initial begin
        heap_reset();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (req_q.size() < 150);
        calm = 1'b1;
        wait (req_q.size() == 0 && grant_q.size() == 0 && !i_valid);
        repeat (500) @(posedge i_clk);
        $display("Ran %0d requests, %0d responses (%0d out of memory, %0d unknown frees).",
                 n_sent, n_done, n_oom, n_unknown);
        if (n_err == 0 && grant_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Cap the run length.
    always @(posedge i_clk) begin
        if (cycles > CycleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end
endmodule
